FILE: hdl/bta_pkg.sv
package bta_pkg;

   // table geometry
   localparam int NUM_BLOCKS  = 1024;
   localparam int BLOCK_BYTES = 4096;
   localparam int BLOCK_SHIFT = $clog2(BLOCK_BYTES);
   localparam int IDX_W       = $clog2(NUM_BLOCKS);
   localparam int CNT_W       = $clog2(NUM_BLOCKS + 1);
   localparam int WIDE_W      = 33;
   localparam int ADDR_W      = 32;
   localparam int BIU_W       = 11;
   localparam int ENTRY_W     = 3;

   // table entry coding
   localparam logic [ENTRY_W-1:0] ENTRY_FREE = 3'b000;
   localparam logic [ENTRY_W-1:0] BIT_TAKEN  = 3'b001;
   localparam logic [ENTRY_W-1:0] BIT_FIRST  = 3'b010;
   localparam logic [ENTRY_W-1:0] BIT_NEXT   = 3'b100;
   localparam int                 NEXT_POS   = 2;

   // register indexes
   localparam logic CSR_HEAP_BASE     = 1'b0;
   localparam logic CSR_BLOCKS_IN_USE = 1'b1;

   localparam logic [BIU_W-1:0] BLOCKS_IN_USE_RESET = 11'd1024;

   // request and response codes
   localparam logic CMD_ALLOC        = 1'b0;
   localparam logic CMD_FREE         = 1'b1;
   localparam logic STATUS_OK        = 1'b0;
   localparam logic STATUS_NO_MEMORY = 1'b1;

   // controller states
   typedef enum logic [6:0] {
      ST_IDLE   = 7'b0000001,
      ST_CLEAR  = 7'b0000010,
      ST_DECODE = 7'b0000100,
      ST_SCAN   = 7'b0001000,
      ST_MARK   = 7'b0010000,
      ST_FREE   = 7'b0100000,
      ST_RESP   = 7'b1000000
   } bta_state_type;

   // controller to datapath
   typedef struct packed {
      logic accept;
      logic decode;
      logic scan;
      logic mark;
      logic rel;
      logic clear;
   } bta_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic clear_done;
      logic is_free;
      logic alloc_fail;
      logic free_skip;
      logic scan_found;
      logic scan_end;
      logic mark_done;
      logic rel_done;
   } bta_sts_type;

endpackage

FILE: hdl/bta_ram.sv
module bta_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // one write port, one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: hdl/bta_ctrl.sv
module bta_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   output logic                 rsp_valid,
   output bta_pkg::bta_cmd_type cmd,
   input  bta_pkg::bta_sts_type sts
);

   bta_pkg::bta_state_type state_ff;
   bta_pkg::bta_state_type state_in;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         bta_pkg::ST_CLEAR: begin
            if (sts.clear_done) state_in = bta_pkg::ST_IDLE;
         end
         bta_pkg::ST_IDLE: begin
            if (start) state_in = bta_pkg::ST_DECODE;
         end
         bta_pkg::ST_DECODE: begin
            if (sts.is_free) begin
               state_in = sts.free_skip ? bta_pkg::ST_RESP : bta_pkg::ST_FREE;
            end else begin
               state_in = sts.alloc_fail ? bta_pkg::ST_RESP : bta_pkg::ST_SCAN;
            end
         end
         bta_pkg::ST_SCAN: begin
            if (sts.scan_found) state_in = bta_pkg::ST_MARK;
            else if (sts.scan_end) state_in = bta_pkg::ST_RESP;
         end
         bta_pkg::ST_MARK: begin
            if (sts.mark_done) state_in = bta_pkg::ST_RESP;
         end
         bta_pkg::ST_FREE: begin
            if (sts.rel_done) state_in = bta_pkg::ST_RESP;
         end
         bta_pkg::ST_RESP: begin
            state_in = bta_pkg::ST_IDLE;
         end
         default: begin
            state_in = bta_pkg::ST_IDLE;
         end
      endcase
   end

   // state register, table clear runs first after reset
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= bta_pkg::ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   // datapath commands
   assign cmd.accept = (state_ff == bta_pkg::ST_IDLE) && start;
   assign cmd.decode = (state_ff == bta_pkg::ST_DECODE);
   assign cmd.scan   = (state_ff == bta_pkg::ST_SCAN);
   assign cmd.mark   = (state_ff == bta_pkg::ST_MARK);
   assign cmd.rel    = (state_ff == bta_pkg::ST_FREE);
   assign cmd.clear  = (state_ff == bta_pkg::ST_CLEAR);

   assign busy      = (state_ff != bta_pkg::ST_IDLE);
   assign rsp_valid = (state_ff == bta_pkg::ST_RESP);

   // checks
   a_rsp_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("response strobe longer than one cycle");

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("accepted transaction did not raise busy");

   a_clear_after_reset: assert property (@(posedge clock) disable iff (reset)
      $fell(reset) |-> busy)
      else $error("table clear not running after reset");

endmodule

FILE: hdl/bta_dp.sv
module bta_dp (
   input  logic                       clock,
   input  logic                       reset,
   input  bta_pkg::bta_cmd_type       cmd,
   output bta_pkg::bta_sts_type       sts,
   input  logic                       req_command,
   input  logic [31:0]                req_request_bytes,
   input  logic [31:0]                req_free_address,
   input  logic                       csr_valid,
   input  logic                       csr_index,
   input  logic [31:0]                csr_data,
   output logic                       rsp_status,
   output logic [bta_pkg::ADDR_W-1:0] rsp_granted_address
);

   localparam int IDX_W  = bta_pkg::IDX_W;
   localparam int CNT_W  = bta_pkg::CNT_W;
   localparam int WIDE_W = bta_pkg::WIDE_W;
   localparam int ADDR_W = bta_pkg::ADDR_W;
   localparam int BIU_W  = bta_pkg::BIU_W;
   localparam int ENT_W  = bta_pkg::ENTRY_W;

   // configuration
   logic [ADDR_W-1:0] base_ff, base_in;
   logic [BIU_W-1:0]  biu_ff, biu_in;

   // latched transaction
   logic              cmd_ff, cmd_in;
   logic [31:0]       bytes_ff, bytes_in;
   logic [31:0]       addr_ff, addr_in;

   // walk state
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [CNT_W-1:0]  need_ff, need_in;
   logic [CNT_W-1:0]  idx_ff, idx_in;
   logic [IDX_W-1:0]  chk_ff, chk_in;
   logic              vld_ff, vld_in;
   logic [CNT_W-1:0]  run_ff, run_in;
   logic [IDX_W-1:0]  start_ff, start_in;
   logic [CNT_W-1:0]  k_ff, k_in;

   // response
   logic              status_ff, status_in;
   logic [ADDR_W-1:0] granted_ff, granted_in;

   // decode arithmetic
   logic [WIDE_W-1:0] biu_wide, num_wide, active_wide, need_wide, block_wide;
   logic [ADDR_W-1:0] offset;

   // table access
   logic              issue;
   logic              entry_free;
   logic [IDX_W-1:0]  run_start;
   logic [CNT_W-1:0]  mark_pos;
   logic              wr_en;
   logic [IDX_W-1:0]  wr_addr;
   logic [ENT_W-1:0]  wr_data;
   logic [ENT_W-1:0]  rd_data;
   logic [ENT_W-1:0]  mark_entry;

   // active count, block count of the request, block of the free address
   assign biu_wide    = {{(WIDE_W-BIU_W){1'b0}}, biu_ff};
   assign num_wide    = WIDE_W'(bta_pkg::NUM_BLOCKS);
   assign active_wide = (biu_wide < num_wide) ? biu_wide : num_wide;
   assign need_wide   = ({1'b0, bytes_ff} + WIDE_W'(bta_pkg::BLOCK_BYTES - 1))
                        >> bta_pkg::BLOCK_SHIFT;
   assign offset      = addr_ff - base_ff;
   assign block_wide  = {1'b0, offset} >> bta_pkg::BLOCK_SHIFT;

   // walk helpers
   assign issue      = (idx_ff < count_ff);
   assign entry_free = (rd_data == bta_pkg::ENTRY_FREE);
   assign run_start  = (run_ff == '0) ? chk_ff : start_ff;
   assign mark_pos   = CNT_W'(start_ff) + k_ff;

   always_comb begin
      mark_entry = bta_pkg::BIT_TAKEN;
      if (k_ff == '0) mark_entry = mark_entry | bta_pkg::BIT_FIRST;
      if ((k_ff + CNT_W'(1)) < need_ff) mark_entry = mark_entry | bta_pkg::BIT_NEXT;
   end

   // status to controller
   assign sts.clear_done = (idx_ff == CNT_W'(bta_pkg::NUM_BLOCKS - 1));
   assign sts.is_free    = (cmd_ff == bta_pkg::CMD_FREE);
   assign sts.alloc_fail = (need_wide == '0) || (need_wide > active_wide);
   assign sts.free_skip  = (block_wide >= active_wide);
   assign sts.scan_found = vld_ff && entry_free && ((run_ff + CNT_W'(1)) == need_ff);
   assign sts.scan_end   = !vld_ff && !issue;
   assign sts.mark_done  = ((k_ff + CNT_W'(1)) == need_ff);
   assign sts.rel_done   = (vld_ff && !rd_data[bta_pkg::NEXT_POS]) || (!vld_ff && !issue);

   // table write port
   always_comb begin
      wr_en   = 1'b0;
      wr_addr = idx_ff[IDX_W-1:0];
      wr_data = bta_pkg::ENTRY_FREE;
      if (cmd.clear) begin
         wr_en = 1'b1;
      end else if (cmd.mark) begin
         wr_en   = 1'b1;
         wr_addr = mark_pos[IDX_W-1:0];
         wr_data = mark_entry;
      end else if (cmd.rel && vld_ff) begin
         wr_en   = 1'b1;
         wr_addr = chk_ff;
      end
   end

   bta_ram #(
      .WIDTH(ENT_W),
      .DEPTH(bta_pkg::NUM_BLOCKS)
   ) u_table (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(wr_addr),
      .wr_data(wr_data),
      .rd_addr(idx_ff[IDX_W-1:0]),
      .rd_data(rd_data)
   );

   // next values
   always_comb begin
      base_in    = base_ff;
      biu_in     = biu_ff;
      cmd_in     = cmd_ff;
      bytes_in   = bytes_ff;
      addr_in    = addr_ff;
      count_in   = count_ff;
      need_in    = need_ff;
      idx_in     = idx_ff;
      chk_in     = chk_ff;
      vld_in     = 1'b0;
      run_in     = run_ff;
      start_in   = start_ff;
      k_in       = k_ff;
      status_in  = status_ff;
      granted_in = granted_ff;

      // register writes
      if (csr_valid) begin
         if (csr_index == bta_pkg::CSR_HEAP_BASE) base_in = csr_data;
         else biu_in = csr_data[BIU_W-1:0];
      end

      // latch transaction
      if (cmd.accept) begin
         cmd_in   = req_command;
         bytes_in = req_request_bytes;
         addr_in  = req_free_address;
      end

      // clearing pass
      if (cmd.clear) begin
         idx_in = idx_ff + CNT_W'(1);
      end

      // set up the walk and a default response
      if (cmd.decode) begin
         count_in   = active_wide[CNT_W-1:0];
         need_in    = need_wide[CNT_W-1:0];
         idx_in     = sts.is_free ? block_wide[CNT_W-1:0] : '0;
         run_in     = '0;
         status_in  = (!sts.is_free && sts.alloc_fail) ? bta_pkg::STATUS_NO_MEMORY
                                                       : bta_pkg::STATUS_OK;
         granted_in = '0;
      end

      // sequential reads, one entry per cycle
      if (cmd.scan || cmd.rel) begin
         vld_in = issue;
         if (issue) begin
            idx_in = idx_ff + CNT_W'(1);
            chk_in = idx_ff[IDX_W-1:0];
         end
      end

      // first-fit run tracking
      if (cmd.scan) begin
         if (vld_ff) begin
            if (entry_free) begin
               run_in   = run_ff + CNT_W'(1);
               start_in = run_start;
            end else begin
               run_in = '0;
            end
         end
         if (sts.scan_found) k_in = '0;
         if (sts.scan_end) status_in = bta_pkg::STATUS_NO_MEMORY;
      end

      // mark the run
      if (cmd.mark) begin
         k_in = k_ff + CNT_W'(1);
         if (sts.mark_done) begin
            granted_in = base_ff + (ADDR_W'(start_ff) << bta_pkg::BLOCK_SHIFT);
         end
      end
   end

   // control and configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         base_ff <= '0;
         biu_ff  <= bta_pkg::BLOCKS_IN_USE_RESET;
         idx_ff  <= '0;
         vld_ff  <= 1'b0;
      end else begin
         base_ff <= base_in;
         biu_ff  <= biu_in;
         idx_ff  <= idx_in;
         vld_ff  <= vld_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      cmd_ff     <= cmd_in;
      bytes_ff   <= bytes_in;
      addr_ff    <= addr_in;
      count_ff   <= count_in;
      need_ff    <= need_in;
      chk_ff     <= chk_in;
      run_ff     <= run_in;
      start_ff   <= start_in;
      k_ff       <= k_in;
      status_ff  <= status_in;
      granted_ff <= granted_in;
   end

   assign rsp_status          = status_ff;
   assign rsp_granted_address = granted_ff;

   // checks
   a_mark_in_range: assert property (@(posedge clock) disable iff (reset)
      cmd.mark |-> (mark_pos < count_ff))
      else $error("run marking past the active block count");

   a_rel_in_range: assert property (@(posedge clock) disable iff (reset)
      (cmd.rel && vld_ff) |-> (CNT_W'(chk_ff) < count_ff))
      else $error("release writes past the active block count");

   a_found_marks: assert property (@(posedge clock) disable iff (reset)
      (cmd.scan && sts.scan_found) |=> (k_ff == '0))
      else $error("marking did not start at the run head");

endmodule

FILE: hdl/block_table_heap_allocator_unit.sv
// First-fit block table heap allocator.
// Input channel: a transaction is taken on a rising edge with start high and
// busy low; req_command selects allocate or free, req_request_bytes and
// req_free_address carry the operands.
// Result channel: exactly one result per transaction, shown for one cycle with
// rsp_valid high; rsp_status and rsp_granted_address are valid in that cycle.
// The receiver cannot stall, so a result is always taken in its strobe cycle.
// Register port: csr_valid/csr_ready with csr_index (0 heap_base,
// 1 blocks_in_use) and csr_data; csr_ready is always high.
// Sequence: allocate runs decode, a first-fit scan of the table up to the
// last block of the fitting run (or the active block count when nothing fits),
// and, when a run fits, a mark of its blocks, then the result; a failed
// size check goes from decode to the result. Free runs decode, then clears
// entries along the chain until one without the next bit or the active block
// count, then the result; an address outside the table goes from decode to
// the result. The table has a single read port and the walk reads one entry
// per cycle. One transaction is in flight at a time.
// Reset: registers return to heap_base 0 and blocks_in_use 1024, then a
// clearing pass writes all 1024 table entries free with
// busy high; register writes are taken during that pass.
module block_table_heap_allocator_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic        req_command,
   input  logic [31:0] req_request_bytes,
   input  logic [31:0] req_free_address,
   output logic        rsp_valid,
   output logic        rsp_status,
   output logic [31:0] rsp_granted_address,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic        csr_index,
   input  logic [31:0] csr_data
);

   bta_pkg::bta_cmd_type cmd;
   bta_pkg::bta_sts_type sts;

   // register writes are always taken
   assign csr_ready = 1'b1;

   // controller
   bta_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .busy     (busy),
      .rsp_valid(rsp_valid),
      .cmd      (cmd),
      .sts      (sts)
   );

   // datapath with the block table
   bta_dp u_dp (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .sts                (sts),
      .req_command        (req_command),
      .req_request_bytes  (req_request_bytes),
      .req_free_address   (req_free_address),
      .csr_valid          (csr_valid && csr_ready),
      .csr_index          (csr_index),
      .csr_data           (csr_data),
      .rsp_status         (rsp_status),
      .rsp_granted_address(rsp_granted_address)
   );

endmodule

FILE: tb/tb_block_table_heap_allocator_unit.sv
module tb_block_table_heap_allocator_unit;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CYCLE_LIMIT    = 3_000_000;
   localparam int TRAFFIC_PHASES = 6;
   localparam int PHASE_ITEMS    = 45;

   typedef struct packed {
      logic        status;
      logic [31:0] addr;
   } grant_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic        busy;
   logic        req_command = bta_pkg::CMD_ALLOC;
   logic [31:0] req_request_bytes = '0;
   logic [31:0] req_free_address = '0;
   logic        rsp_valid;
   logic        rsp_status;
   logic [31:0] rsp_granted_address;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic        csr_index = bta_pkg::CSR_HEAP_BASE;
   logic [31:0] csr_data = '0;

   // predictor state: block table and register copies
   logic [bta_pkg::ENTRY_W-1:0] block_map [bta_pkg::NUM_BLOCKS];
   logic [31:0]                 heap_base_reg;
   logic [bta_pkg::BIU_W-1:0]   blocks_in_use_reg;

   grant_type expected_grants [$];
   int        live_heads [$];
   int        mismatch_count = 0;

   // idle pattern state
   int calm_left = 0;
   bit calm_mode = 1'b0;

   block_table_heap_allocator_unit dut (
      .clock               (clock),
      .reset               (reset),
      .start               (start),
      .busy                (busy),
      .req_command         (req_command),
      .req_request_bytes   (req_request_bytes),
      .req_free_address    (req_free_address),
      .rsp_valid           (rsp_valid),
      .rsp_status          (rsp_status),
      .rsp_granted_address (rsp_granted_address),
      .csr_valid           (csr_valid),
      .csr_ready           (csr_ready),
      .csr_index           (csr_index),
      .csr_data            (csr_data)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   function automatic int active_blocks();
      return (blocks_in_use_reg > bta_pkg::NUM_BLOCKS) ? bta_pkg::NUM_BLOCKS
                                                       : int'(blocks_in_use_reg);
   endfunction

   // first-fit allocate or chained release on the predictor table
   function automatic grant_type apply_heap_request(input logic cmd, input logic [31:0] bytes,
                                                    input logic [31:0] addr,
                                                    output int head_block);
      grant_type                   g;
      logic [63:0]                 need;
      int                          run;
      int                          first;
      int                          active;
      bit                          found;
      logic [31:0]                 offset;
      logic [31:0]                 blk;
      logic [bta_pkg::ENTRY_W-1:0] e;
      g.status   = bta_pkg::STATUS_OK;
      g.addr     = '0;
      head_block = -1;
      active     = active_blocks();
      if (cmd == bta_pkg::CMD_ALLOC) begin
         need  = ({32'd0, bytes} + 64'(bta_pkg::BLOCK_BYTES - 1)) >> bta_pkg::BLOCK_SHIFT;
         found = 1'b0;
         run   = 0;
         first = 0;
         if (need != 0 && need <= 64'(active)) begin
            for (int i = 0; i < active && !found; i++) begin
               if (block_map[i] != bta_pkg::ENTRY_FREE) begin
                  run = 0;
               end else begin
                  if (run == 0) first = i;
                  run++;
                  if (64'(run) == need) found = 1'b1;
               end
            end
         end
         if (!found) begin
            g.status = bta_pkg::STATUS_NO_MEMORY;
         end else begin
            for (int k = 0; 64'(k) < need; k++) begin
               e = bta_pkg::BIT_TAKEN;
               if (k == 0) e = e | bta_pkg::BIT_FIRST;
               if (64'(k + 1) < need) e = e | bta_pkg::BIT_NEXT;
               block_map[first + k] = e;
            end
            g.addr     = heap_base_reg + (32'(first) << bta_pkg::BLOCK_SHIFT);
            head_block = first;
         end
      end else begin
         offset = addr - heap_base_reg;
         blk    = offset >> bta_pkg::BLOCK_SHIFT;
         if (blk < 32'(active)) begin
            for (int i = int'(blk); i < active; i++) begin
               e            = block_map[i];
               block_map[i] = bta_pkg::ENTRY_FREE;
               if (!e[bta_pkg::NEXT_POS]) break;
            end
         end
      end
      return g;
   endfunction

   // stretches of back-to-back requests alternate with random gaps
   function int draw_gap();
      if (calm_left == 0) begin
         calm_left = $urandom_range(4, 24);
         calm_mode = ($urandom_range(0, 2) == 0);
      end
      calm_left--;
      return calm_mode ? 0 : $urandom_range(0, 18);
   endfunction

   // one request transaction; start stays high for a follow-up with no gap
   task automatic send_request(input logic cmd, input logic [31:0] bytes,
                               input logic [31:0] addr);
      int        gap;
      int        head;
      grant_type g;
      gap = draw_gap();
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start             <= 1'b1;
      req_command       <= cmd;
      req_request_bytes <= bytes;
      req_free_address  <= addr;
      do @(posedge clock); while (busy);
      g = apply_heap_request(cmd, bytes, addr, head);
      expected_grants.push_back(g);
      if (head >= 0) live_heads.push_back(head);
   endtask

   task automatic alloc_bytes(input logic [31:0] bytes);
      send_request(bta_pkg::CMD_ALLOC, bytes, $urandom);
   endtask

   task automatic free_at(input logic [31:0] addr);
      send_request(bta_pkg::CMD_FREE, $urandom, addr);
   endtask

   // wait for every outstanding response and an idle block
   task automatic settle_block();
      start <= 1'b0;
      while (expected_grants.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
      while (busy) @(posedge clock);
   endtask

   task automatic write_reg(input logic idx, input logic [31:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      do @(posedge clock); while (!csr_ready);
      if (idx == bta_pkg::CSR_HEAP_BASE) heap_base_reg = data;
      else blocks_in_use_reg = data[bta_pkg::BIU_W-1:0];
   endtask

   // both registers, upper data bits of the block count left random
   task automatic program_heap(input logic [31:0] base, input int count);
      logic [31:0] word;
      settle_block();
      word = {21'($urandom_range(0, 2097151)), count[bta_pkg::BIU_W-1:0]};
      write_reg(bta_pkg::CSR_HEAP_BASE, base);
      write_reg(bta_pkg::CSR_BLOCKS_IN_USE, word);
      csr_valid <= 1'b0;
   endtask

   // size rounding, oversized requests and a run cut short at the table end
   task automatic test_size_rounding();
      program_heap(32'h0, 1024);
      alloc_bytes(32'd0);
      alloc_bytes(32'd1);
      alloc_bytes(32'd4096);
      alloc_bytes(32'd4097);
      alloc_bytes(32'hFFFF_FFFF);
      alloc_bytes(32'h0040_0000);
      alloc_bytes(32'h003F_C001);
      alloc_bytes(32'h003F_C000);
      free_at(32'h0000_4000);
   endtask

   // release of tails, middles, free blocks and out-of-range addresses
   task automatic test_release_cases();
      free_at(32'h0000_3000);
      free_at(32'h0000_2005);
      free_at(32'h0000_5000);
      free_at(32'hFFFF_F000);
      free_at(32'h0040_0000);
      alloc_bytes(32'd12288);
      free_at(32'h0000_3000);
      free_at(32'h0000_1000);
   endtask

   // address wrap, zero and single block counts, count above the table size
   task automatic test_register_extremes();
      program_heap(32'hFFFF_F000, 2047);
      alloc_bytes(32'd8192);
      alloc_bytes(32'd4096);
      free_at(32'h0000_2000);
      program_heap(32'h0, 0);
      alloc_bytes(32'd1);
      free_at(32'h0);
      program_heap(32'h0001_0000, 1);
      alloc_bytes(32'd1);
      free_at(32'h0001_0000);
      alloc_bytes(32'd1);
      alloc_bytes(32'd1);
      program_heap(32'h0, 1024);
      free_at(32'h0000_2000);
      free_at(32'h0);
   endtask

   // mostly allocate/release pairs, with oversized, zero and stray requests
   task automatic send_random_request();
      int          pick;
      int          idx;
      int          head;
      logic [31:0] addr;
      pick = $urandom_range(0, 99);
      if (pick < 40) begin
         alloc_bytes($urandom_range(1, 4 * bta_pkg::BLOCK_BYTES));
      end else if (pick < 50) begin
         alloc_bytes($urandom_range(1, 32 * bta_pkg::BLOCK_BYTES));
      end else if (pick < 54) begin
         alloc_bytes($urandom);
      end else if (pick < 57) begin
         alloc_bytes(32'd0);
      end else if (pick < 85 && live_heads.size() != 0) begin
         idx  = $urandom_range(0, live_heads.size() - 1);
         head = live_heads[idx];
         live_heads.delete(idx);
         addr = heap_base_reg + (32'(head) << bta_pkg::BLOCK_SHIFT);
         if ($urandom_range(0, 3) == 0) begin
            addr = addr + $urandom_range(0, bta_pkg::BLOCK_BYTES - 1);
         end
         free_at(addr);
      end else if (pick < 93) begin
         addr = heap_base_reg
                + (32'($urandom_range(0, active_blocks() + 3)) << bta_pkg::BLOCK_SHIFT)
                + $urandom_range(0, bta_pkg::BLOCK_BYTES - 1);
         free_at(addr);
      end else begin
         free_at($urandom);
      end
   endtask

   task automatic test_random_traffic();
      int          biu_plan [TRAFFIC_PHASES];
      logic [31:0] base;
      biu_plan = '{1024, 48, 2, 2047, 700, 1024};
      for (int p = 0; p < TRAFFIC_PHASES; p++) begin
         if (p == 0) base = 32'h0;
         else if (p == 3) base = $urandom;
         else base = {20'($urandom_range(0, 1048575)), 12'h000};
         program_heap(base, biu_plan[p]);
         repeat (PHASE_ITEMS) send_random_request();
      end
   endtask

   // response check against the oldest outstanding expectation
   always @(posedge clock) begin
      grant_type want;
      if (!reset && rsp_valid) begin
         if (expected_grants.size() == 0) begin
            $error("rsp_valid with no transaction outstanding");
            mismatch_count++;
         end else begin
            want = expected_grants.pop_front();
            if (rsp_status !== want.status) begin
               $error("rsp_status expected %0d actual %0d", want.status, rsp_status);
               mismatch_count++;
            end
            if (rsp_granted_address !== want.addr) begin
               $error("rsp_granted_address expected %h actual %h",
                      want.addr, rsp_granted_address);
               mismatch_count++;
            end
         end
      end
   end

   // watchdog
   initial begin
      int unsigned cycles;
      cycles = 0;
      while (cycles < CYCLE_LIMIT) begin
         @(posedge clock);
         cycles++;
      end
      $display("[block_table_heap_allocator_unit] ERROR");
      $finish;
   end

   initial begin
      for (int i = 0; i < bta_pkg::NUM_BLOCKS; i++) block_map[i] = bta_pkg::ENTRY_FREE;
      heap_base_reg     = '0;
      blocks_in_use_reg = bta_pkg::BLOCKS_IN_USE_RESET;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      test_size_rounding();
      test_release_cases();
      test_register_extremes();
      test_random_traffic();
      settle_block();
      repeat (16) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("[block_table_heap_allocator_unit] OK");
      end else begin
         $display("[block_table_heap_allocator_unit] ERROR");
      end
      $finish;
   end

endmodule
